@@ sv/vpfrgba_pkg.sv @@
package vpfrgba_pkg;

	localparam int MAX_WIDTH = 4096;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int FW_W = 13;
	localparam int FMT_W = 3;
	// wide enough for column + 2 and for any width value
	localparam int SUM_W = ((COL_W > FW_W) ? COL_W : FW_W) + 1;

	typedef enum logic [FMT_W-1:0] {
		FMT_BGRA32 = 3'd0,
		FMT_BGR24  = 3'd1,
		FMT_YUY2   = 3'd2,
		FMT_NV12   = 3'd3,
		FMT_RED    = 3'd4
	} fmt_t;

	typedef enum logic {
		REG_FORMAT = 1'b0,
		REG_WIDTH  = 1'b1
	} reg_idx_t;

	localparam logic [FW_W-1:0] WIDTH_RESET = 13'd640;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	// per-item decision from the column tracker
	typedef struct packed {
		logic two_px;
	} col_info_t;

endpackage

@@ sv/vpfrgba_yuv.sv @@
module vpfrgba_yuv (
	input  logic [7:0] y,
	input  logic [7:0] u,
	input  logic [7:0] v,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic signed [19:0] c, d, e;
	logic signed [19:0] c298;
	logic signed [19:0] acc_r, acc_g, acc_b;

	function automatic logic [7:0] clamp_shift(input logic signed [19:0] acc);
		logic signed [11:0] sh;
		sh = 12'(acc >>> 8);
		if (sh < 0) begin
			return 8'd0;
		end else if (sh > 12'sd255) begin
			return 8'd255;
		end else begin
			return sh[7:0];
		end
	endfunction

	assign c = $signed({12'd0, y}) - 20'sd16;
	assign d = $signed({12'd0, u}) - 20'sd128;
	assign e = $signed({12'd0, v}) - 20'sd128;

	assign c298  = c * 20'sd298;
	assign acc_r = c298 + e * 20'sd409 + 20'sd128;
	assign acc_g = c298 - d * 20'sd100 - e * 20'sd208 + 20'sd128;
	assign acc_b = c298 + d * 20'sd516 + 20'sd128;

	assign red   = clamp_shift(acc_r);
	assign green = clamp_shift(acc_g);
	assign blue  = clamp_shift(acc_b);

endmodule

@@ sv/vpfrgba_col.sv @@
module vpfrgba_col (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  vpfrgba_pkg::fmt_t             fmt,
	input  logic [vpfrgba_pkg::FW_W-1:0]  frame_width,
	output vpfrgba_pkg::col_info_t        info
);

	logic [vpfrgba_pkg::COL_W-1:0] col_q;
	logic [vpfrgba_pkg::SUM_W-1:0] fw_ext, eff_w, col_ext, col_next;

	assign fw_ext = vpfrgba_pkg::SUM_W'(frame_width);

	// width of zero acts as one, above the maximum it saturates
	always_comb begin
		if (fw_ext == '0) begin
			eff_w = vpfrgba_pkg::SUM_W'(1);
		end else if (fw_ext > vpfrgba_pkg::SUM_W'(vpfrgba_pkg::MAX_WIDTH)) begin
			eff_w = vpfrgba_pkg::SUM_W'(vpfrgba_pkg::MAX_WIDTH);
		end else begin
			eff_w = fw_ext;
		end
	end

	assign col_ext = vpfrgba_pkg::SUM_W'(col_q);
	assign info.two_px = (fmt == vpfrgba_pkg::FMT_YUY2) &&
		((col_ext + vpfrgba_pkg::SUM_W'(1)) < eff_w);
	assign col_next = col_ext + (info.two_px ? vpfrgba_pkg::SUM_W'(2) : vpfrgba_pkg::SUM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (advance) begin
			if (col_next >= eff_w) begin
				col_q <= '0;
			end else begin
				col_q <= col_next[vpfrgba_pkg::COL_W-1:0];
			end
		end
	end

endmodule

@@ sv/video_pixel_format_to_rgba.sv @@
// Pixel format converter: source pixel words in, RGBA pixels out.
// s_tdata carries one source word; the format register picks how its bytes
// are read (BGRA32, BGR24, YUY2, NV12, anything else gives opaque red).
// m_tdata carries one RGBA pixel, m_tlast marks the last pixel of a word.
// APB registers: 0x0 pixel_format, 0x4 frame_width (row length used for
// the YUY2 odd-width row end). Change them only while the stream is idle.
// A word accepted on the slave side passes through the input register, then
// the output register, before its first pixel reaches the master side.
// Throughput: one word per cycle for single-pixel formats while the receiver
// does not stall; a YUY2 word that gives two pixels stays in the input register
// until the output register has taken both, one pixel per cycle.
// When the receiver stalls the output register holds its beat and the input
// register fills, after which s_tready drops; no beat is lost.
// Reset clears the column position, both valid flags and sets the
// registers to BGRA32 and a width of 640.
module video_pixel_format_to_rgba (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // byte_0, byte_1, byte_2, byte_3
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red, green, blue, alpha
	output logic        m_tlast,   // last_of_run
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	vpfrgba_pkg::fmt_t              fmt_q;
	logic [vpfrgba_pkg::FW_W-1:0]   width_q;
	vpfrgba_pkg::reg_idx_t          reg_sel;
	logic                           cfg_wr;

	logic                           s1_valid;
	logic [31:0]                    data_s1;
	vpfrgba_pkg::fmt_t              fmt_s1;
	logic                           two_s1;
	logic                           phase_s1;

	vpfrgba_pkg::col_info_t         col_info;
	logic                           in_acc, out_load, last_beat;
	logic [7:0]                     yuv_y, yuv_v, yuv_r, yuv_g, yuv_b;
	vpfrgba_pkg::pixel_t            pix;

	logic                           out_valid_q;
	vpfrgba_pkg::pixel_t            pix_q;
	logic                           last_q;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = vpfrgba_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= vpfrgba_pkg::FMT_BGRA32;
			width_q <= vpfrgba_pkg::WIDTH_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				vpfrgba_pkg::REG_FORMAT: fmt_q <= vpfrgba_pkg::fmt_t'(pwdata[vpfrgba_pkg::FMT_W-1:0]);
				vpfrgba_pkg::REG_WIDTH:  width_q <= pwdata[vpfrgba_pkg::FW_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			vpfrgba_pkg::REG_FORMAT: prdata = 32'(fmt_q);
			vpfrgba_pkg::REG_WIDTH:  prdata = 32'(width_q);
			default:                 prdata = '0;
		endcase
	end

	// handshakes
	assign last_beat = !two_s1 || phase_s1;
	assign out_load  = s1_valid && (!out_valid_q || m_tready);
	assign s_tready  = !s1_valid || (out_load && last_beat);
	assign in_acc    = s_tvalid && s_tready;

	vpfrgba_col u_col (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (in_acc),
		.fmt         (fmt_q),
		.frame_width (width_q),
		.info        (col_info)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			phase_s1 <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid <= s_tvalid;
			end
			if (in_acc) begin
				phase_s1 <= 1'b0;
			end else if (out_load && !last_beat) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_s1 <= s_tdata;
			fmt_s1  <= fmt_q;
			two_s1  <= col_info.two_px;
		end
	end

	// second yuy2 pixel takes Y1, nv12 takes V from byte 2
	assign yuv_y = phase_s1 ? data_s1[23:16] : data_s1[7:0];
	assign yuv_v = (fmt_s1 == vpfrgba_pkg::FMT_NV12) ? data_s1[23:16] : data_s1[31:24];

	vpfrgba_yuv u_yuv (
		.y     (yuv_y),
		.u     (data_s1[15:8]),
		.v     (yuv_v),
		.red   (yuv_r),
		.green (yuv_g),
		.blue  (yuv_b)
	);

	always_comb begin
		case (fmt_s1)
			vpfrgba_pkg::FMT_BGRA32: pix = '{data_s1[23:16], data_s1[15:8], data_s1[7:0], data_s1[31:24]};
			vpfrgba_pkg::FMT_BGR24:  pix = '{data_s1[23:16], data_s1[15:8], data_s1[7:0], 8'd255};
			vpfrgba_pkg::FMT_YUY2,
			vpfrgba_pkg::FMT_NV12:   pix = '{yuv_r, yuv_g, yuv_b, 8'd255};
			default:                 pix = '{8'd255, 8'd0, 8'd0, 8'd255};
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pix_q  <= pix;
			last_q <= last_beat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {pix_q.alpha, pix_q.blue, pix_q.green, pix_q.red};
	assign m_tlast  = last_q;

endmodule
